### src/mtr_pkg.sv
// ----------------------------------------------------------------------------
// mtr_pkg
// shared constants of the ranged twister generator: operation codes,
// recurrence constants and state geometry
// ----------------------------------------------------------------------------
package mtr_pkg;

    localparam int unsigned ADDR_W = 10;
    localparam int unsigned WORD_W = 32;

    localparam logic [1:0] OP_SEED   = 2'd0;
    localparam logic [1:0] OP_RAW    = 2'd1;
    localparam logic [1:0] OP_RANGED = 2'd2;

    localparam int unsigned WORD_COUNT = 624;
    localparam logic [ADDR_W-1:0] LAST_IDX   = 10'd623;
    localparam logic [ADDR_W-1:0] SHIFT_OFS  = 10'd397;
    localparam logic [ADDR_W-1:0] WRAP_START = 10'd227;

    localparam logic [WORD_W-1:0] MIX_MULT   = 32'd1664525;
    localparam logic [WORD_W-1:0] MIX_ADD    = 32'd1013904223;
    localparam logic [WORD_W-1:0] INIT_MULT  = 32'h6c078965;
    localparam logic [WORD_W-1:0] UPPER_MASK = 32'h80000000;
    localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fffffff;
    localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908b0df;
    localparam logic [WORD_W-1:0] ALL_ONES   = 32'hffffffff;

endpackage

### src/mtr_ram.sv
// ----------------------------------------------------------------------------
// mtr_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mtr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### src/mtr_mod.sv
// ----------------------------------------------------------------------------
// mtr_mod
// bit-serial restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mtr_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_dvd;
    logic [31:0] r_dsr;
    logic [32:0] n_shift;

    assign n_shift = {o_rem, r_dvd[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                o_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_dsr}) begin
                    o_rem <= 32'(n_shift - {1'b0, r_dsr});
                end else begin
                    o_rem <= n_shift[31:0];
                end
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

### src/mersenne_twister_ranged_rng.sv
// ----------------------------------------------------------------------------
// mersenne_twister_ranged_rng
// 624-word twister generator with raw and ranged draws, untempered output
// ----------------------------------------------------------------------------
// usage: one request channel (i_valid/o_ready) carries operation, seed and
// range; one response channel (o_valid/i_ready) returns number and
// range_error, exactly one response per request transfer. requests are
// handled one at a time; a new request is taken while the last response
// still waits in the output register.
// structure: the state lives in a single 624-entry ram with two read ports.
// a seed runs SEED_MIX_ROUNDS mix rounds and then fills the state, each mix
// round and each fill word a multiply then an add. a raw draw reads one word,
// and when the read index wraps the state is first twisted in place (read,
// then write, per word). a ranged draw adds the limit remainder and the final
// remainder from the serial remainder unit, plus one draw per rejected word.
// range zero and the unused code answer without a draw.
// reset clears the index and marks the state unseeded; draws then return
// zero without twisting until the first seed. a stalled receiver
// holds the response; the next result waits until the register is free.
// ----------------------------------------------------------------------------
module mersenne_twister_ranged_rng #(
    parameter int unsigned SEED_MIX_ROUNDS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_range_limit,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_number,
    output logic        o_range_error
);

    localparam int unsigned RND_W = $clog2(SEED_MIX_ROUNDS + 2);
    localparam int unsigned AW = mtr_pkg::ADDR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MIX_MUL, S_MIX_ADD, S_FILL_MUL, S_FILL_ADD, S_LIM_DIV,
        S_DRAW, S_TW_PRE, S_TW_RD, S_TW_WR, S_RD_ISSUE, S_RD_DATA,
        S_MOD_DIV, S_RESP
    } t_state;

    t_state           r_state;
    logic [1:0]       r_op;
    logic [31:0]      r_range;
    logic [31:0]      r_val;
    logic [31:0]      r_prod;
    logic [31:0]      r_cur;
    logic [31:0]      r_limit;
    logic [31:0]      r_num;
    logic             r_err;
    logic             r_seeded;
    logic [RND_W-1:0] r_rnd;
    logic [AW-1:0]    r_k;
    logic [AW-1:0]    r_pos;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    logic [31:0]   mem_rdata_a;
    logic [31:0]   mem_rdata_b;

    logic        div_start;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [31:0] div_rem;

    logic [31:0] n_fill;
    logic [31:0] n_y;
    logic [31:0] n_tw;
    logic [31:0] n_word;

    assign o_ready = (r_state == S_IDLE);

    assign n_fill = r_prod + {22'd0, r_k};
    assign n_y    = (r_cur & mtr_pkg::UPPER_MASK) | (mem_rdata_a & mtr_pkg::LOWER_MASK);
    assign n_tw   = mem_rdata_b ^ (n_y >> 1) ^ (n_y[0] ? mtr_pkg::TWIST_XOR : 32'd0);
    assign n_word = r_seeded ? mem_rdata_a : 32'd0;

    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_k;
        mem_wdata   = n_fill;
        mem_raddr_a = r_pos;
        mem_raddr_b = '0;
        unique case (r_state)
            S_MIX_MUL: begin
                if (r_rnd == RND_W'(SEED_MIX_ROUNDS)) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = r_val;
                end
            end
            S_FILL_ADD: begin
                mem_we = 1'b1;
            end
            S_TW_PRE: begin
                mem_raddr_a = '0;
            end
            S_TW_RD: begin
                mem_raddr_a = (r_k == mtr_pkg::LAST_IDX) ? '0 : r_k + 10'd1;
                mem_raddr_b = (r_k >= mtr_pkg::WRAP_START) ? r_k - mtr_pkg::WRAP_START
                                                           : r_k + mtr_pkg::SHIFT_OFS;
            end
            S_TW_WR: begin
                mem_we    = 1'b1;
                mem_wdata = n_tw;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = n_word;
        div_divisor  = r_range;
        if (r_state == S_IDLE && i_valid && i_operation == mtr_pkg::OP_RANGED
            && i_range_limit != 32'd0) begin
            div_start    = 1'b1;
            div_dividend = mtr_pkg::ALL_ONES;
            div_divisor  = i_range_limit;
        end else if (r_state == S_RD_DATA && r_op == mtr_pkg::OP_RANGED
                     && n_word < r_limit) begin
            div_start = 1'b1;
        end
    end

    mtr_ram #(
        .WIDTH(32),
        .DEPTH(mtr_pkg::WORD_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .o_rdata_a (mem_rdata_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_b (mem_rdata_b)
    );

    mtr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seeded <= 1'b0;
            r_pos    <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (i_ready && r_state != S_RESP) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_operation;
                        r_range <= i_range_limit;
                        r_val   <= i_seed_value;
                        r_rnd   <= '0;
                        r_num   <= '0;
                        r_err   <= 1'b0;
                        if (i_operation == mtr_pkg::OP_SEED) begin
                            r_state <= S_MIX_MUL;
                        end else if (i_operation == mtr_pkg::OP_RAW) begin
                            r_state <= S_DRAW;
                        end else if (i_operation == mtr_pkg::OP_RANGED) begin
                            if (i_range_limit == 32'd0) begin
                                r_err   <= 1'b1;
                                r_state <= S_RESP;
                            end else begin
                                r_state <= S_LIM_DIV;
                            end
                        end else begin
                            r_state <= S_RESP;
                        end
                    end
                end
                S_MIX_MUL: begin
                    if (r_rnd == RND_W'(SEED_MIX_ROUNDS)) begin
                        r_k     <= 10'd1;
                        r_state <= S_FILL_MUL;
                    end else begin
                        r_prod  <= 32'(mtr_pkg::MIX_MULT * r_val);
                        r_state <= S_MIX_ADD;
                    end
                end
                S_MIX_ADD: begin
                    r_val   <= r_prod + mtr_pkg::MIX_ADD;
                    r_rnd   <= r_rnd + RND_W'(1);
                    r_state <= S_MIX_MUL;
                end
                S_FILL_MUL: begin
                    r_prod  <= 32'(mtr_pkg::INIT_MULT * (r_val ^ (r_val >> 30)));
                    r_state <= S_FILL_ADD;
                end
                S_FILL_ADD: begin
                    r_val <= n_fill;
                    if (r_k == mtr_pkg::LAST_IDX) begin
                        r_pos    <= '0;
                        r_seeded <= 1'b1;
                        r_state  <= S_RESP;
                    end else begin
                        r_k     <= r_k + 10'd1;
                        r_state <= S_FILL_MUL;
                    end
                end
                S_LIM_DIV: begin
                    if (div_done) begin
                        r_limit <= mtr_pkg::ALL_ONES - div_rem;
                        r_state <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    if (r_pos == '0 && r_seeded) begin
                        r_state <= S_TW_PRE;
                    end else begin
                        r_state <= S_RD_ISSUE;
                    end
                end
                S_TW_PRE: begin
                    r_k     <= '0;
                    r_state <= S_TW_RD;
                end
                S_TW_RD: begin
                    if (r_k == '0) begin
                        r_cur <= mem_rdata_a;
                    end
                    r_state <= S_TW_WR;
                end
                S_TW_WR: begin
                    r_cur <= mem_rdata_a;
                    if (r_k == mtr_pkg::LAST_IDX) begin
                        r_state <= S_RD_ISSUE;
                    end else begin
                        r_k     <= r_k + 10'd1;
                        r_state <= S_TW_RD;
                    end
                end
                S_RD_ISSUE: begin
                    r_state <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    r_pos <= (r_pos == mtr_pkg::LAST_IDX) ? '0 : r_pos + 10'd1;
                    if (r_op == mtr_pkg::OP_RAW) begin
                        r_num   <= n_word;
                        r_state <= S_RESP;
                    end else if (n_word >= r_limit) begin
                        r_state <= S_DRAW;
                    end else begin
                        r_state <= S_MOD_DIV;
                    end
                end
                S_MOD_DIV: begin
                    if (div_done) begin
                        r_num   <= div_rem;
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!o_valid || i_ready) begin
                        o_valid       <= 1'b1;
                        o_number      <= r_num;
                        o_range_error <= r_err;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/mtr_checker.sv
// ----------------------------------------------------------------------------
// mtr_checker
// port-level checks of the ranged twister generator, bound to the top level
// ----------------------------------------------------------------------------
module mtr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_number,
    input logic        o_range_error
);

    // a stalled response holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_number) && $stable(o_range_error))
        else $error("stalled response changed");

    // error responses carry zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_number == 32'd0)
        else $error("error response with nonzero number");

    // reset empties the response register and opens the request side
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("bad state after reset");

endmodule

bind mersenne_twister_ranged_rng mtr_checker u_mtr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_number      (o_number),
    .o_range_error (o_range_error)
);

### test/mtr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtr_tb_checker
// watches both channels of the ranged twister generator, keeps its own copy
// of the 624-word state, predicts each response and compares it field by field
// ----------------------------------------------------------------------------
module mtr_tb_checker #(
    parameter int unsigned SEED_MIX_ROUNDS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_req,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_range_limit,
    input  logic        i_valid_rsp,
    input  logic        i_ready,
    input  logic [31:0] i_number,
    input  logic        i_range_error,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_rsp_count,
    output int          o_reject_count
);

    typedef struct packed {
        logic [31:0] number;
        logic        range_error;
    } t_response;

    logic [31:0] twister_state [mtr_pkg::WORD_COUNT];
    int unsigned draw_idx;
    t_response   expected_q [$];

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic void load_seed(input logic [31:0] seed);
        logic [31:0] v;
        v = seed;
        for (int r = 0; r < SEED_MIX_ROUNDS; r++) v = mtr_pkg::MIX_MULT * v + mtr_pkg::MIX_ADD;
        twister_state[0] = v;
        for (int k = 1; k < mtr_pkg::WORD_COUNT; k++)
            twister_state[k] = mtr_pkg::INIT_MULT
                               * (twister_state[k-1] ^ (twister_state[k-1] >> 30))
                               + 32'(k);
        draw_idx = 0;
    endfunction

    function automatic logic [31:0] next_word();
        logic [31:0] y;
        logic [31:0] w;
        if (draw_idx == 0) begin
            for (int k = 0; k < mtr_pkg::WORD_COUNT; k++) begin
                y = (twister_state[k] & mtr_pkg::UPPER_MASK)
                    | (twister_state[(k + 1) % mtr_pkg::WORD_COUNT] & mtr_pkg::LOWER_MASK);
                w = twister_state[(k + 397) % mtr_pkg::WORD_COUNT] ^ (y >> 1);
                if (y[0]) w ^= mtr_pkg::TWIST_XOR;
                twister_state[k] = w;
            end
        end
        w = twister_state[draw_idx];
        draw_idx = (draw_idx + 1) % mtr_pkg::WORD_COUNT;
        return w;
    endfunction

    function automatic t_response predict_response(input logic [1:0] op,
                                                   input logic [31:0] seed,
                                                   input logic [31:0] span);
        t_response   r;
        logic [31:0] bound;
        logic [31:0] w;
        r = '0;
        case (op)
            mtr_pkg::OP_SEED: load_seed(seed);
            mtr_pkg::OP_RAW: r.number = next_word();
            mtr_pkg::OP_RANGED: begin
                if (span == 0) begin
                    r.range_error = 1'b1;
                end else begin
                    bound = mtr_pkg::ALL_ONES - (mtr_pkg::ALL_ONES % span);
                    w = next_word();
                    while (w >= bound) begin
                        o_reject_count++;
                        w = next_word();
                    end
                    r.number = w % span;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_rsp_count = 0;
        o_reject_count = 0;
        o_pending = 0;
        draw_idx = 0;
        foreach (twister_state[k]) twister_state[k] = '0;
    end

    always @(posedge i_clk) begin
        t_response want;
        if (i_rst_n) begin
            if (i_valid_rsp && i_ready) begin
                o_rsp_count++;
                if (expected_q.size() == 0) begin
                    report($sformatf("unexpected response number %08h", i_number));
                end else begin
                    want = expected_q.pop_front();
                    if (i_number !== want.number)
                        report($sformatf("number %08h, expected %08h", i_number, want.number));
                    if (i_range_error !== want.range_error)
                        report($sformatf("range_error %b, expected %b", i_range_error,
                                         want.range_error));
                end
            end
            if (i_valid && i_ready_req)
                expected_q.push_back(predict_response(i_operation, i_seed_value,
                                                      i_range_limit));
        end
        o_pending = expected_q.size();
    end

endmodule

### test/tb_mersenne_twister_ranged_rng.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mersenne_twister_ranged_rng
// drives seeds, raw and ranged draws through the generator under varying
// sender and receiver idling; the checker predicts and compares responses
// ----------------------------------------------------------------------------
module tb_mersenne_twister_ranged_rng;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [31:0] i_seed_value;
    logic [31:0] i_range_limit;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_number;
    logic        o_range_error;

    int fail_count;
    int pending;
    int rsp_count;
    int reject_count;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    int items_sent;

    mersenne_twister_ranged_rng dut (.*);

    mtr_tb_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ready_req   (o_ready),
        .i_operation   (i_operation),
        .i_seed_value  (i_seed_value),
        .i_range_limit (i_range_limit),
        .i_valid_rsp   (o_valid),
        .i_ready       (i_ready),
        .i_number      (o_number),
        .i_range_error (o_range_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_rsp_count   (rsp_count),
        .o_reject_count(reject_count)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] seed,
                             input logic [31:0] span);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_seed_value <= seed;
        i_range_limit <= span;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [31:0] pick_span();
        case ($urandom_range(5))
            0: return 32'($urandom_range(1, 10));
            1: return 32'($urandom_range(1, 1000));
            2: return $urandom();
            3: return 32'h80000000 + 32'($urandom_range(1, 1000));
            4: return 32'hffffffff - 32'($urandom_range(0, 3));
            default: return 32'(1) << $urandom_range(31);
        endcase
    endfunction

    task automatic random_phase(input int count, input int idle, input int stall);
        int pick;
        send_idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 3) send_item(mtr_pkg::OP_SEED, $urandom(), $urandom());
            else if (pick < 45) send_item(mtr_pkg::OP_RAW, $urandom(), $urandom());
            else if (pick < 96) send_item(mtr_pkg::OP_RANGED, $urandom(), pick_span());
            else if (pick < 98) send_item(mtr_pkg::OP_RANGED, $urandom(), 32'd0);
            else send_item(OP_UNUSED, $urandom(), $urandom());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_operation = mtr_pkg::OP_SEED;
        i_seed_value = '0;
        i_range_limit = '0;
        hold_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unseeded draws, unused code, range zero and one, field extremes
        send_item(mtr_pkg::OP_RAW, 32'hffffffff, 32'hffffffff);
        send_item(mtr_pkg::OP_RANGED, '0, 32'd7);
        send_item(OP_UNUSED, 32'hffffffff, 32'hffffffff);
        send_item(mtr_pkg::OP_RANGED, '0, 32'd0);
        send_item(mtr_pkg::OP_SEED, 32'd0, '0);
        send_item(mtr_pkg::OP_RAW, '0, '0);
        send_item(mtr_pkg::OP_RANGED, '0, 32'd1);
        send_item(mtr_pkg::OP_RANGED, '0, 32'hffffffff);
        send_item(mtr_pkg::OP_RANGED, '0, 32'h80000000);
        send_item(mtr_pkg::OP_RANGED, '0, 32'h80000001);
        send_item(mtr_pkg::OP_SEED, 32'hffffffff, 32'hffffffff);
        send_item(mtr_pkg::OP_RANGED, 32'hffffffff, 32'd0);
        send_item(OP_UNUSED, '0, '0);
        send_item(mtr_pkg::OP_RAW, '0, '0);
        send_item(mtr_pkg::OP_SEED, 32'h12345678, '0);
        send_item(mtr_pkg::OP_RANGED, '0, 32'd6);
        send_item(mtr_pkg::OP_RAW, '0, '0);

        random_phase(250, 0, 0);
        random_phase(180, 82, 0);
        random_phase(180, 0, 82);
        // long receiver hold-off while items keep coming
        hold_cycles = 2000;
        random_phase(60, 0, 0);
        random_phase(180, 27, 27);
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        $display("%0d requests, %0d responses, %0d rejected words", items_sent, rsp_count,
                 reject_count);
        $display("covered seeds, raw and ranged draws, range zero and one, unused code");
        if (fail_count == 0 && pending == 0)
            $display("PASS mersenne_twister_ranged_rng");
        else
            $display("FAIL mersenne_twister_ranged_rng");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL mersenne_twister_ranged_rng");
        $finish;
    end

endmodule

### sim.f
src/mtr_pkg.sv
src/mtr_ram.sv
src/mtr_mod.sv
src/mersenne_twister_ranged_rng.sv
src/mtr_checker.sv
test/mtr_checker.sv
test/tb_mersenne_twister_ranged_rng.sv
